// ----- design/ppdm_pkg.sv -----
// ppdm_pkg: shared widths, constants and types of the PWM period/duty meter.
// No dependencies; imported by every module of the meter.
`timescale 1ns / 1ps
`default_nettype none
package ppdm_pkg;

  localparam int COUNT_BITS = 16;
  localparam int RATE_W     = 27;
  localparam int FREQ_W     = 26;
  localparam int DUTY_W     = 7;
  localparam int TICKS_W    = 16;
  localparam int PER_W      = COUNT_BITS + 1;
  localparam int PROD_W     = COUNT_BITS + DUTY_W;
  localparam int DIV_W      = (RATE_W > PROD_W) ? RATE_W : PROD_W;
  localparam int CNT_W      = $clog2(DIV_W);
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX  = {COUNT_BITS{1'b1}};
  localparam logic [RATE_W-1:0]     RATE_RESET = RATE_W'(1000000);
  localparam logic [DUTY_W-1:0]     PERCENT    = DUTY_W'(100);

  // one finished pair of counts
  typedef struct packed {
    logic [COUNT_BITS-1:0] high_cnt;
    logic [COUNT_BITS-1:0] low_cnt;
    logic                  sat;
  } meas_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage
`default_nettype wire

// ----- design/ppdm_front.sv -----
// ppdm_front: edge detection and high/low tick counting on the sampled pin.
// Depends on ppdm_pkg; pushes finished measurements into ppdm_fifo.
`timescale 1ns / 1ps
`default_nettype none
module ppdm_front (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire                    in_level,
  input  ppdm_pkg::fifo_stat_t   fifo_stat,
  output logic                   push,
  output ppdm_pkg::meas_t        push_data
);
  import ppdm_pkg::*;

  typedef enum logic [2:0] {
    PH_WAIT = 3'b001,
    PH_HIGH = 3'b010,
    PH_LOW  = 3'b100
  } phase_t;

  phase_t                phase_r, phase_nxt;
  logic                  prev_r, prev_nxt;
  logic [COUNT_BITS-1:0] tick_r, tick_nxt;
  logic [COUNT_BITS-1:0] high_r, high_nxt;
  logic                  sat_r, sat_nxt;
  logic                  xfer, rise, fall, emit;

  assign in_ready = ~fifo_stat.full;
  assign xfer     = in_valid & in_ready;
  assign rise     = ~prev_r & in_level;
  assign fall     = prev_r & ~in_level;
  assign push     = xfer & emit;
  assign push_data = '{high_cnt: high_r, low_cnt: tick_r, sat: sat_r};

  always_comb begin
    phase_nxt = phase_r;
    prev_nxt  = prev_r;
    tick_nxt  = tick_r;
    high_nxt  = high_r;
    sat_nxt   = sat_r;
    emit      = 1'b0;
    if (xfer) begin
      prev_nxt = in_level;
      unique case (phase_r)
        PH_HIGH: begin
          if (fall) begin
            high_nxt  = tick_r;
            tick_nxt  = COUNT_BITS'(1);
            phase_nxt = PH_LOW;
          end else if (tick_r == COUNT_MAX) begin
            sat_nxt = 1'b1;
          end else begin
            tick_nxt = tick_r + COUNT_BITS'(1);
          end
        end
        PH_LOW: begin
          if (rise) begin
            emit      = 1'b1;
            phase_nxt = PH_WAIT;
          end else if (tick_r == COUNT_MAX) begin
            sat_nxt = 1'b1;
          end else begin
            tick_nxt = tick_r + COUNT_BITS'(1);
          end
        end
        default: begin
          phase_nxt = PH_WAIT;
          if (rise) begin
            tick_nxt  = COUNT_BITS'(1);
            high_nxt  = '0;
            sat_nxt   = 1'b0;
            phase_nxt = PH_HIGH;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WAIT;
      prev_r  <= 1'b1;
      tick_r  <= '0;
      high_r  <= '0;
      sat_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      prev_r  <= prev_nxt;
      tick_r  <= tick_nxt;
      high_r  <= high_nxt;
      sat_r   <= sat_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- design/ppdm_fifo.sv -----
// ppdm_fifo: small queue of finished measurements between front and back.
// Depends on ppdm_pkg (meas_t, FIFO_DEPTH).
`timescale 1ns / 1ps
`default_nettype none
module ppdm_fifo (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   push,
  input  ppdm_pkg::meas_t       push_data,
  input  wire                   pop,
  output ppdm_pkg::meas_t       head,
  output ppdm_pkg::fifo_stat_t  stat
);
  import ppdm_pkg::*;

  meas_t              mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]   cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign stat.full  = (cnt_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push & ~stat.full;
  assign do_pop     = pop & ~stat.empty;
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + (FIFO_AW+1)'(1);
    else if (do_pop && !do_push) cnt_nxt = cnt_r - (FIFO_AW+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- design/ppdm_back.sv -----
// ppdm_back: frequency and duty computation with one shared restoring divider,
// plus the result output register. Depends on ppdm_pkg; reads from ppdm_fifo.
`timescale 1ns / 1ps
`default_nettype none
module ppdm_back (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire [ppdm_pkg::RATE_W-1:0]   rate,
  input  ppdm_pkg::meas_t              head,
  input  ppdm_pkg::fifo_stat_t         fifo_stat,
  output logic                         pop,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [ppdm_pkg::FREQ_W-1:0]  out_frequency,
  output logic [ppdm_pkg::DUTY_W-1:0]  out_duty_percent,
  output logic [ppdm_pkg::TICKS_W-1:0] out_high_ticks,
  output logic [ppdm_pkg::TICKS_W-1:0] out_low_ticks,
  output logic                         out_overflow
);
  import ppdm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_FREQ = 4'b0010,
    S_DUTY = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t                state_r;
  meas_t                 meas_r;
  logic [PER_W-1:0]      div_r;
  logic [PROD_W-1:0]     prod_r;
  logic [DIV_W-1:0]      quo_r, quo_nxt;
  logic [PER_W-1:0]      rem_r, rem_nxt;
  logic [CNT_W-1:0]      cnt_r;
  logic [FREQ_W-1:0]     freq_r;
  logic [DUTY_W-1:0]     duty_r;
  logic [PER_W:0]        rem_sh;
  logic                  ge, out_free;

  // one restoring step per cycle
  assign rem_sh  = {rem_r, quo_r[DIV_W-1]};
  assign ge      = (rem_sh >= {1'b0, div_r});
  assign rem_nxt = ge ? PER_W'(rem_sh - {1'b0, div_r}) : PER_W'(rem_sh);
  assign quo_nxt = {quo_r[DIV_W-2:0], ge};

  assign pop      = (state_r == S_IDLE) & ~fifo_stat.empty;
  assign out_free = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state_r)
        S_IDLE: if (pop) state_r <= S_FREQ;
        S_FREQ: if (cnt_r == '0) state_r <= S_DUTY;
        S_DUTY: if (cnt_r == '0) state_r <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state_r   <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        meas_r <= head;
        div_r  <= PER_W'(head.high_cnt) + PER_W'(head.low_cnt);
        prod_r <= PROD_W'(head.high_cnt) * PROD_W'(PERCENT);
        quo_r  <= DIV_W'(rate);
        rem_r  <= '0;
        cnt_r  <= CNT_W'(DIV_W - 1);
      end
      S_FREQ: begin
        if (cnt_r == '0) begin
          freq_r <= FREQ_W'(quo_nxt);
          quo_r  <= DIV_W'(prod_r);
          rem_r  <= '0;
          cnt_r  <= CNT_W'(DIV_W - 1);
        end else begin
          quo_r <= quo_nxt;
          rem_r <= rem_nxt;
          cnt_r <= cnt_r - CNT_W'(1);
        end
      end
      S_DUTY: begin
        quo_r <= quo_nxt;
        rem_r <= rem_nxt;
        if (cnt_r == '0) duty_r <= DUTY_W'(quo_nxt);
        else cnt_r <= cnt_r - CNT_W'(1);
      end
      S_OUT: begin
        if (out_free) begin
          out_frequency    <= freq_r;
          out_duty_percent <= duty_r;
          out_high_ticks   <= TICKS_W'(meas_r.high_cnt);
          out_low_ticks    <= TICKS_W'(meas_r.low_cnt);
          out_overflow     <= meas_r.sat;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ----- design/pwm_period_duty_meter_top.sv -----
// A result is computed once the closing rising edge's tick is transferred and queued;
// the shared bit-per-cycle divider then runs twice (frequency, duty).
// Throughput: one tick per cycle while fewer than 4 measurements wait in the queue;
// in_ready drops when the queue is full; the divider takes one measurement at a time.
// Reset (rst_n, synchronous, active low): waiting for a rising edge with the previous
// level taken as high, queue empty, no result pending, tick rate 1000000 Hz.
`timescale 1ns / 1ps
`default_nettype none
module pwm_period_duty_meter_top (
  input  wire                          clk,
  input  wire                          rst_n,
  // tick input channel
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire                          in_level,
  // result channel
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [ppdm_pkg::FREQ_W-1:0]  out_frequency,
  output logic [ppdm_pkg::DUTY_W-1:0]  out_duty_percent,
  output logic [ppdm_pkg::TICKS_W-1:0] out_high_ticks,
  output logic [ppdm_pkg::TICKS_W-1:0] out_low_ticks,
  output logic                         out_overflow,
  // tick rate register
  input  wire                          cfg_we,
  input  wire  [ppdm_pkg::RATE_W-1:0]  cfg_wdata
);
  import ppdm_pkg::*;

  logic [RATE_W-1:0] rate_r;
  fifo_stat_t        fifo_stat;
  meas_t             push_data, head;
  logic              push, pop;

  // Tick rate, the frequency dividend. Only written while the meter is idle (a user rule,
  // not enforced by the block), so the back end reads it live at the start of each division.
  always_ff @(posedge clk) begin
    if (!rst_n) rate_r <= RATE_RESET;
    else if (cfg_we) rate_r <= cfg_wdata;
  end

  // Front: one tick per transfer, edge detect, saturating counters.
  ppdm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_level  (in_level),
    .fifo_stat (fifo_stat),
    .push      (push),
    .push_data (push_data)
  );

  // Queue of finished count pairs; decouples ticks from the slow divider.
  ppdm_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .stat      (fifo_stat)
  );

  // Back: frequency = rate/period, duty = high*100/period, output register.
  ppdm_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .rate             (rate_r),
    .head             (head),
    .fifo_stat        (fifo_stat),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_frequency    (out_frequency),
    .out_duty_percent (out_duty_percent),
    .out_high_ticks   (out_high_ticks),
    .out_low_ticks    (out_low_ticks),
    .out_overflow     (out_overflow)
  );

  // The front never pushes into a full queue (in_ready guards it).
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && fifo_stat.full))
    else $error("measurement pushed into full queue");

  // Duty is a percentage of the period.
  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_duty_percent <= DUTY_W'(100)))
    else $error("duty above 100 percent");

  // Both phases last at least one tick, so the period is never below two.
  a_freq_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_frequency <= FREQ_W'(rate_r >> 1)) &&
                   (out_high_ticks != '0) && (out_low_ticks != '0)))
    else $error("frequency or counts out of range");

endmodule
`default_nettype wire
